// ----- design/rtp_pkg.sv -----
`timescale 1ns / 1ps
package rtp_pkg;

  localparam int unsigned NUMBER_MAX_DEF = 65535;
  localparam int unsigned OCTAVE_MAX_DEF = 9;

  localparam logic [1:0] KIND_NOTE = 2'd0;
  localparam logic [1:0] KIND_REST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  typedef enum logic [1:0] {
    OP_NOTE = 2'd0,
    OP_REST = 2'd1,
    OP_STOP = 2'd2
  } op_t;

  // One queued job for the back end.
  typedef struct packed {
    op_t         op;
    logic [1:0]  stop_kind;
    logic [15:0] len;
    logic [15:0] bpm;
    logic        dotted;
    logic [7:0]  midi;
    logic [15:0] offset;
    logic        last;
  } job_t;

  function automatic logic [24:0] semitone_ratio(input logic [3:0] r);
    logic [24:0] v;
    begin
      unique case (r)
        4'd0:    v = 25'd16777216;
        4'd1:    v = 25'd17774841;
        4'd2:    v = 25'd18831788;
        4'd3:    v = 25'd19951585;
        4'd4:    v = 25'd21137968;
        4'd5:    v = 25'd22394897;
        4'd6:    v = 25'd23726566;
        4'd7:    v = 25'd25137421;
        4'd8:    v = 25'd26632170;
        4'd9:    v = 25'd28215802;
        4'd10:   v = 25'd29893600;
        4'd11:   v = 25'd31671166;
        default: v = 25'd16777216;
      endcase
      return v;
    end
  endfunction

  function automatic logic [3:0] letter_semitone(input logic [2:0] l);
    logic [3:0] v;
    begin
      unique case (l)
        3'd0:    v = 4'd9;
        3'd1:    v = 4'd11;
        3'd2:    v = 4'd0;
        3'd3:    v = 4'd2;
        3'd4:    v = 4'd4;
        3'd5:    v = 4'd5;
        3'd6:    v = 4'd7;
        default: v = 4'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- design/rtp_front.sv -----
`timescale 1ns / 1ps
module rtp_front
  import rtp_pkg::*;
#(
  parameter int unsigned NUMBER_MAX = NUMBER_MAX_DEF,
  parameter int unsigned OCTAVE_MAX = OCTAVE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       job_valid,
  output job_t       job,
  input  logic       job_ready
);

  typedef enum logic [3:0] {
    PH_NAME, PH_HDR, PH_EQ, PH_HNUM, PH_LEN, PH_SHARP, PH_DOT, PH_OCT, PH_COMMA, PH_STOP
  } phase_t;

  phase_t      phase, ph_n;
  logic [15:0] number_accum, na_n;
  logic [15:0] default_length, dl_n;
  logic [3:0]  default_oct, do_n;
  logic [15:0] tempo_bpm, tb_n;
  logic [1:0]  header_key, hk_n;
  logic [15:0] cur_len, cl_n;
  logic        cur_dot, cd_n;
  logic [3:0]  cur_semitone, cs_n;
  logic        cur_is_rest, cr_n;
  logic [15:0] byte_offset;

  // Up to two jobs per byte, held until the queue takes them.
  job_t        j0, j1, j0_n, j1_n;
  logic [1:0]  jcnt, jn;
  logic        jsel;

  logic [7:0]  c, u;
  logic        dig;
  logic [15:0] pos;
  logic [20:0] acc_w;
  logic [15:0] acc_v;

  assign full = (jcnt != 2'd0);
  assign job_valid = full;
  assign job = jsel ? j1 : j0;

  function automatic job_t mk_stop(input logic [1:0] k, input logic [15:0] off);
    job_t t;
    begin
      t = '0;
      t.op = OP_STOP;
      t.stop_kind = k;
      t.offset = off;
      return t;
    end
  endfunction

  always_comb begin
    logic        again, bad, hs_ok, eot;
    logic [15:0] endpos;
    logic [3:0]  oct;
    logic [1:0]  n;
    job_t        nt;
    c = text_byte;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    dig = (c >= 8'h30 && c <= 8'h39);
    pos = byte_offset;
    eot = end_of_text;
    acc_w = {5'd0, number_accum} * 21'd10 + {13'd0, c - 8'h30};
    acc_v = (acc_w > 21'(NUMBER_MAX)) ? 16'(NUMBER_MAX) : acc_w[15:0];
    ph_n = phase; na_n = number_accum; dl_n = default_length; do_n = default_oct;
    tb_n = tempo_bpm; hk_n = header_key; cl_n = cur_len; cd_n = cur_dot;
    cs_n = cur_semitone; cr_n = cur_is_rest;
    j0_n = '0; j1_n = '0; n = 2'd0;
    bad = 1'b0; hs_ok = 1'b0; oct = '0; nt = '0; endpos = '0;
    again = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (again && ph_n != PH_STOP) begin
        again = 1'b0;
        unique case (ph_n)
          PH_NAME: if (c == 8'h3a) ph_n = PH_HDR;
          PH_HDR: begin
            if (c == 8'h20 || c == 8'h0a) begin
            end else if (c == 8'h3a) begin
              ph_n = PH_LEN; na_n = '0;
            end else if (u == 8'h44 || u == 8'h4f || u == 8'h42) begin
              hk_n = (u == 8'h44) ? 2'd0 : ((u == 8'h4f) ? 2'd1 : 2'd2);
              ph_n = PH_EQ;
            end else bad = 1'b1;
          end
          PH_EQ: begin
            if (c == 8'h3d) begin
              ph_n = PH_HNUM; na_n = '0;
            end else bad = 1'b1;
          end
          PH_HNUM: begin
            if (dig) na_n = acc_v;
            else if (na_n == '0) bad = 1'b1;
            else begin
              priority case (hk_n)
                2'd0: dl_n = na_n;
                2'd1: do_n = (na_n > 16'(OCTAVE_MAX)) ? 4'(OCTAVE_MAX) : na_n[3:0];
                default: tb_n = na_n;
              endcase
              ph_n = PH_HDR;
              if (c != 8'h2c) again = 1'b1;
            end
          end
          PH_LEN: begin
            if (dig) na_n = acc_v;
            else if ((u >= 8'h41 && u <= 8'h47) || u == 8'h50) begin
              cl_n = (na_n != '0) ? na_n : dl_n;
              cd_n = 1'b0;
              na_n = '0;
              if (u == 8'h50) begin
                cr_n = 1'b1; cs_n = '0; ph_n = PH_DOT;
              end else begin
                cr_n = 1'b0; cs_n = letter_semitone(3'(u - 8'h41)); ph_n = PH_SHARP;
              end
            end else bad = 1'b1;
          end
          PH_SHARP: begin
            ph_n = PH_DOT;
            if (c == 8'h23) cs_n = cs_n + 4'd1;
            else again = 1'b1;
          end
          PH_DOT: begin
            ph_n = cr_n ? PH_COMMA : PH_OCT;
            if (c == 8'h2e) cd_n = 1'b1;
            else again = 1'b1;
          end
          PH_OCT: begin
            if (dig) na_n = acc_v;
            else begin
              ph_n = PH_COMMA; again = 1'b1;
            end
          end
          PH_COMMA: begin
            if (c == 8'h2c) begin
              n = n + 2'd1; ph_n = PH_LEN;
            end else bad = 1'b1;
          end
          default: ph_n = PH_STOP;
        endcase
        if (bad) begin
          if (n == 2'd0) j0_n = mk_stop(KIND_BAD, pos);
          ph_n = PH_STOP;
          n = 2'd1;
          bad = 1'b0;
        end
      end
    end
    // Build the note job from the state at emission time.
    oct = (na_n != '0) ? ((na_n > 16'(OCTAVE_MAX)) ? 4'(OCTAVE_MAX) : na_n[3:0])
                       : do_n;
    nt = '0;
    nt.op = cr_n ? OP_REST : OP_NOTE;
    nt.len = cl_n;
    nt.bpm = tb_n;
    nt.dotted = cd_n;
    nt.midi = cr_n ? 8'd0 : 8'({4'd0, cs_n} + ({4'd0, oct} + 8'd1) * 8'd12);
    if (n == 2'd1 && ph_n != PH_STOP) begin
      j0_n = nt;
      na_n = '0;
    end
    if (eot) begin
      endpos = (pos != 16'hffff) ? pos + 16'd1 : pos;
      if (ph_n == PH_HNUM) begin
        hs_ok = (na_n != '0);
        if (hs_ok) begin
          priority case (hk_n)
            2'd0: dl_n = na_n;
            2'd1: do_n = (na_n > 16'(OCTAVE_MAX)) ? 4'(OCTAVE_MAX) : na_n[3:0];
            default: tb_n = na_n;
          endcase
        end
        j0_n = mk_stop(hs_ok ? KIND_END : KIND_BAD, endpos);
        n = 2'd1;
      end else if (ph_n == PH_SHARP || ph_n == PH_DOT || ph_n == PH_OCT ||
                   ph_n == PH_COMMA) begin
        if (n == 2'd0) begin
          j0_n = nt; j1_n = mk_stop(KIND_END, endpos);
        end else j1_n = mk_stop(KIND_END, endpos);
        n = 2'd2;
        if (n == 2'd2 && j0_n.op == OP_STOP) begin
        end
      end else if (ph_n != PH_STOP) begin
        if (n == 2'd0) j0_n = mk_stop(KIND_END, endpos);
        else j1_n = mk_stop(KIND_END, endpos);
        n = n + 2'd1;
      end
      ph_n = PH_NAME; na_n = '0; hk_n = '0; cl_n = '0; cd_n = 1'b0;
      cs_n = '0; cr_n = 1'b0;
    end
    if (n == 2'd1) j0_n.last = 1'b1;
    if (n == 2'd2) j1_n.last = 1'b1;
    jn = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NAME;
      number_accum <= '0;
      default_length <= 16'd4;
      default_oct <= 4'd4;
      tempo_bpm <= 16'd120;
      header_key <= '0;
      cur_len <= '0;
      cur_dot <= 1'b0;
      cur_semitone <= '0;
      cur_is_rest <= 1'b0;
      byte_offset <= '0;
      jcnt <= '0;
      jsel <= 1'b0;
    end else if (push && !full) begin
      phase <= ph_n;
      number_accum <= na_n;
      default_length <= dl_n;
      default_oct <= do_n;
      tempo_bpm <= tb_n;
      header_key <= hk_n;
      cur_len <= cl_n;
      cur_dot <= cd_n;
      cur_semitone <= cs_n;
      cur_is_rest <= cr_n;
      byte_offset <= end_of_text ? 16'd0
                   : ((byte_offset != 16'hffff) ? byte_offset + 16'd1 : byte_offset);
      j0 <= j0_n;
      j1 <= j1_n;
      jcnt <= jn;
      jsel <= 1'b0;
    end else if (job_valid && job_ready) begin
      jcnt <= jcnt - 2'd1;
      jsel <= 1'b1;
    end
  end

endmodule

// ----- design/rtp_queue.sv -----
`timescale 1ns / 1ps
module rtp_queue
  import rtp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  job_t in_job,
  output logic in_ready,
  output logic out_valid,
  output job_t out_job,
  input  logic out_ready
);

  job_t       mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign in_ready = (cnt != 3'd4);
  assign out_valid = (cnt != 3'd0);
  assign out_job = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= wp + 2'd1;
      if (out_valid && out_ready) rp <= rp + 2'd1;
      cnt <= cnt + {2'd0, in_valid && in_ready} - {2'd0, out_valid && out_ready};
    end
  end

endmodule

// ----- design/rtp_back.sv -----
`timescale 1ns / 1ps
module rtp_back
  import rtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_ready,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  midi_note,
  output logic [11:0] freq_hz,
  output logic [18:0] duration_ms,
  output logic [15:0] stop_offset,
  output logic        last
);

  typedef enum logic [2:0] {S_IDLE, S_DIV1, S_DIV2, S_FREQ, S_DONE} state_t;

  state_t      state;
  job_t        cur;
  logic [20:0] quo;
  logic [20:0] rem;
  logic [15:0] dsr;
  logic [4:0]  bitn;
  logic [20:0] rtry;
  logic        step_ge;
  logic [20:0] rem_nx;
  logic [20:0] quo_nx;
  logic [3:0]  mr;
  logic [3:0]  mq;
  logic [31:0] fprod;
  logic [43:0] fsh;

  assign job_ready = (state == S_IDLE) && empty;
  assign rtry = {rem[19:0], quo[20]};
  assign step_ge = (rtry >= {5'd0, dsr});
  assign rem_nx = step_ge ? (rtry - {5'd0, dsr}) : rtry;
  assign quo_nx = {quo[19:0], step_ge};

  // The octave is (midi + 3) / 12, taken as a multiply by 171 and a shift by 11.
  always_comb begin
    logic [7:0]  m8;
    logic [15:0] mprod;
    m8 = cur.midi + 8'd3;
    mprod = {8'd0, m8} * 16'd171;
    mq = mprod[14:11];
    mr = 4'(m8 - 8'({4'd0, mq} * 8'd12));
  end

  always_comb begin
    if (mq >= 4'd6) fsh = ({12'd0, fprod} << (mq - 4'd6)) >> 24;
    else fsh = {12'd0, fprod} >> (5'd24 + 5'(4'd6 - mq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!empty && pop) empty <= 1'b1;
          if (job_valid && job_ready) begin
            cur <= job;
            if (job.op == OP_STOP) begin
              kind <= job.stop_kind; midi_note <= '0; freq_hz <= '0;
              duration_ms <= '0; stop_offset <= job.offset; last <= job.last;
              empty <= 1'b0;
            end else begin
              quo <= 21'd60000; rem <= '0; dsr <= job.bpm; bitn <= '0;
              state <= S_DIV1;
            end
          end
        end
        S_DIV1, S_DIV2: begin
          if (bitn == 5'd20) begin
            bitn <= '0;
            if (state == S_DIV1) begin
              quo <= {quo_nx[18:0], 2'b00};
              rem <= '0;
              dsr <= cur.len;
              state <= S_DIV2;
            end else begin
              quo <= quo_nx;
              rem <= rem_nx;
              state <= S_FREQ;
              fprod <= 32'd110 * {7'd0, semitone_ratio(mr)};
            end
          end else begin
            quo <= quo_nx;
            rem <= rem_nx;
            bitn <= bitn + 5'd1;
          end
        end
        S_FREQ: begin
          duration_ms <= cur.dotted ? 19'(quo + (quo >> 1)) : quo[18:0];
          freq_hz <= (cur.op == OP_REST) ? 12'd0
                   : ((fsh > 44'd4095) ? 12'd4095 : fsh[11:0]);
          kind <= (cur.op == OP_REST) ? KIND_REST : KIND_NOTE;
          midi_note <= cur.midi;
          stop_offset <= '0;
          last <= cur.last;
          state <= S_DONE;
        end
        S_DONE: begin
          empty <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/ringtone_text_note_parser.sv -----
`timescale 1ns / 1ps
// Ringtone text parser: push one text byte at a time while full is low; each byte is
// classified as it is taken and gives up to two result items, which a four-deep queue
// hands to the back end. The back end works out a note or rest with its two 21-step
// shift-subtract divisions for the duration, and takes no new item until its result is popped.
module ringtone_text_note_parser
  import rtp_pkg::*;
#(
  parameter int unsigned NUMBER_MAX = NUMBER_MAX_DEF,
  parameter int unsigned OCTAVE_MAX = OCTAVE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  midi_note,
  output logic [11:0] freq_hz,
  output logic [18:0] duration_ms,
  output logic [15:0] stop_offset,
  output logic        last
);

  logic fv, fr, qv, qr;
  job_t fj, qj;

  rtp_front #(.NUMBER_MAX(NUMBER_MAX), .OCTAVE_MAX(OCTAVE_MAX)) u_front (
    .clk, .rst, .push, .full, .text_byte, .end_of_text,
    .job_valid(fv), .job(fj), .job_ready(fr)
  );

  rtp_queue u_queue (
    .clk, .rst, .in_valid(fv), .in_job(fj), .in_ready(fr),
    .out_valid(qv), .out_job(qj), .out_ready(qr)
  );

  rtp_back u_back (
    .clk, .rst, .job_valid(qv), .job(qj), .job_ready(qr),
    .empty, .pop, .kind, .midi_note, .freq_hz, .duration_ms, .stop_offset, .last
  );

endmodule

// ----- design/rtp_checker.sv -----
`timescale 1ns / 1ps
module rtp_checker
  import rtp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic [7:0]  midi_note,
  input logic [11:0] freq_hz,
  input logic [15:0] stop_offset
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind)))
    else $error("result changed while waiting");

  a_rest: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_REST) |-> (midi_note == 8'd0 && freq_hz == 12'd0))
    else $error("rest with pitch");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_END || kind == KIND_BAD)) |->
      (midi_note == 8'd0 && freq_hz == 12'd0))
    else $error("stop with pitch");

  a_note: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_NOTE) |-> (stop_offset == 16'd0 && midi_note >= 8'd12))
    else $error("bad note fields");

endmodule

bind ringtone_text_note_parser rtp_checker u_chk (
  .clk, .rst, .empty, .pop, .kind, .midi_note, .freq_hz, .stop_offset
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import rtp_pkg::*;

  localparam int unsigned NUM_MAX = 65535;
  localparam int unsigned OCT_MAX = 9;
  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef enum int {
    ST_NAME, ST_HDR, ST_EQ, ST_HNUM, ST_LEN, ST_SHARP, ST_DOT, ST_OCT, ST_COMMA, ST_STOP
  } parse_st_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  midi;
    logic [11:0] freq;
    logic [18:0] dur;
    logic [15:0] off;
    logic        last;
  } result_t;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } text_item_t;

  logic clk, rst, push, full, end_of_text, empty, pop, last;
  logic [7:0] text_byte, midi_note;
  logic [1:0] kind;
  logic [11:0] freq_hz;
  logic [18:0] duration_ms;
  logic [15:0] stop_offset;

  ringtone_text_note_parser DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .text_byte(text_byte),
    .end_of_text(end_of_text), .empty(empty), .pop(pop), .kind(kind),
    .midi_note(midi_note), .freq_hz(freq_hz), .duration_ms(duration_ms),
    .stop_offset(stop_offset), .last(last)
  );

  text_item_t pending_text[$];
  result_t expected_results[$];
  int unsigned errors = 0, n_sent = 0, n_notes = 0, n_rests = 0, n_stops = 0;
  int unsigned cycles = 0;

  parse_st_t st;
  int unsigned acc, dflt_len, dflt_oct, bpm, hkey, cur_dur, cur_semi, byte_pos;
  bit cur_rest;

  const int unsigned ratio_tab[12] = '{
    16777216, 17774841, 18831788, 19951585, 21137968, 22394897,
    23726566, 25137421, 26632170, 28215802, 29893600, 31671166};
  const int unsigned letter_tab[7] = '{9, 11, 0, 2, 4, 5, 7};

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic result_t mk(int unsigned k, int unsigned m, int unsigned f,
                                 int unsigned d, int unsigned o);
    result_t r;
    r.kind = k[1:0];
    r.midi = m[7:0];
    r.freq = f[11:0];
    r.dur = d[18:0];
    r.off = o[15:0];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int unsigned pitch_hz(int unsigned midi);
    int unsigned m;
    int q;
    longint unsigned v, f;
    m = midi + 3;
    q = int'(m / 12) - 6;
    v = 64'd110 * ratio_tab[m % 12];
    if (q >= 0) f = (v << q) >> 24;
    else f = v >> (24 - q);
    return (f > 4095) ? 4095 : int'(f);
  endfunction

  function automatic void add_digit(logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - 8'h30);
    acc = (v > NUM_MAX) ? NUM_MAX : v;
  endfunction

  function automatic bit store_header();
    if (acc == 0) return 1'b0;
    if (hkey == 0) dflt_len = acc;
    else if (hkey == 1) dflt_oct = (acc > OCT_MAX) ? OCT_MAX : acc;
    else bpm = acc;
    return 1'b1;
  endfunction

  function automatic result_t note_result();
    int unsigned oct, midi;
    if (cur_rest) return mk(KIND_REST, 0, 0, cur_dur, 0);
    oct = (acc != 0) ? acc : dflt_oct;
    if (oct > OCT_MAX) oct = OCT_MAX;
    midi = cur_semi + (oct + 1) * 12;
    return mk(KIND_NOTE, midi, pitch_hz(midi), cur_dur, 0);
  endfunction

  function automatic void clear_parse();
    st = ST_NAME;
    acc = 0;
    hkey = 0;
    cur_dur = 0;
    cur_semi = 0;
    cur_rest = 0;
    byte_pos = 0;
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic eot);
    result_t outs[$];
    int unsigned pos, endpos, len, tempo;
    logic [7:0] u;
    bit dig, again, bad;
    pos = byte_pos;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    dig = (c >= "0" && c <= "9");
    again = 1;
    bad = 0;
    if (byte_pos < 65535) byte_pos++;
    while (again && st != ST_STOP) begin
      again = 0;
      case (st)
        ST_NAME: if (c == ":") st = ST_HDR;
        ST_HDR: begin
          if (c == " " || c == 8'h0a) begin
          end else if (c == ":") begin
            st = ST_LEN;
            acc = 0;
          end else if (u == "D" || u == "O" || u == "B") begin
            hkey = (u == "D") ? 0 : ((u == "O") ? 1 : 2);
            st = ST_EQ;
          end else bad = 1;
        end
        ST_EQ: begin
          if (c == "=") begin
            st = ST_HNUM;
            acc = 0;
          end else bad = 1;
        end
        ST_HNUM: begin
          if (dig) add_digit(c);
          else if (!store_header()) bad = 1;
          else begin
            st = ST_HDR;
            if (c != ",") again = 1;
          end
        end
        ST_LEN: begin
          if (dig) add_digit(c);
          else if ((u >= "A" && u <= "G") || u == "P") begin
            len = (acc != 0) ? acc : dflt_len;
            tempo = (bpm != 0) ? bpm : 1;
            if (len == 0) len = 1;
            cur_dur = ((60000 / tempo) * 4) / len;
            acc = 0;
            if (u == "P") begin
              cur_rest = 1;
              cur_semi = 0;
              st = ST_DOT;
            end else begin
              cur_rest = 0;
              cur_semi = letter_tab[u - "A"];
              st = ST_SHARP;
            end
          end else bad = 1;
        end
        ST_SHARP: begin
          st = ST_DOT;
          if (c == "#") cur_semi++;
          else again = 1;
        end
        ST_DOT: begin
          st = cur_rest ? ST_COMMA : ST_OCT;
          if (c == ".") cur_dur += cur_dur / 2;
          else again = 1;
        end
        ST_OCT: begin
          if (dig) add_digit(c);
          else begin
            st = ST_COMMA;
            again = 1;
          end
        end
        ST_COMMA: begin
          if (c == ",") begin
            outs.push_back(note_result());
            st = ST_LEN;
            acc = 0;
          end else bad = 1;
        end
        default: st = ST_STOP;
      endcase
      if (bad) begin
        outs.push_back(mk(KIND_BAD, 0, 0, 0, pos));
        st = ST_STOP;
      end
    end
    if (eot) begin
      endpos = (pos < 65535) ? pos + 1 : 65535;
      if (st == ST_HNUM) begin
        outs.push_back(mk(store_header() ? KIND_END : KIND_BAD, 0, 0, 0, endpos));
      end else if (st >= ST_SHARP && st <= ST_COMMA) begin
        outs.push_back(note_result());
        outs.push_back(mk(KIND_END, 0, 0, 0, endpos));
      end else if (st != ST_STOP) begin
        outs.push_back(mk(KIND_END, 0, 0, 0, endpos));
      end
      clear_parse();
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    text_item_t it;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_byte(text_byte, end_of_text);
        n_sent++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          push <= 1'b0;
        end else if (pending_text.size() > 0) begin
          it = pending_text.pop_front();
          text_byte <= it.b;
          end_of_text <= it.e;
          push <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall-free stretches alternate with stretches of random or periodic stalls.
  always @(posedge clk) begin
    result_t exp_r;
    cycles++;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: kind %0d offset %0d", kind, stop_offset);
        end else begin
          exp_r = expected_results.pop_front();
          if (kind == KIND_NOTE) n_notes++;
          else if (kind == KIND_REST) n_rests++;
          else n_stops++;
          if (kind !== exp_r.kind || midi_note !== exp_r.midi || freq_hz !== exp_r.freq ||
              duration_ms !== exp_r.dur || stop_offset !== exp_r.off ||
              last !== exp_r.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp k%0d m%0d f%0d d%0d o%0d l%0d, got k%0d m%0d f%0d d%0d o%0d l%0d",
                       exp_r.kind, exp_r.midi, exp_r.freq, exp_r.dur, exp_r.off, exp_r.last,
                       kind, midi_note, freq_hz, duration_ms, stop_offset, last);
          end
        end
      end
      case (cycles[11:10])
        2'd0: pop <= 1'b1;
        2'd1: pop <= ($urandom_range(0, 3) != 0);
        2'd2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (cycles[3:0] < 4'd9);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** ringtone_text_note_parser: FAILED **");
      $finish;
    end
  end

  task automatic add_text(input string s);
    text_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.b = s[i];
      it.e = (i == s.len() - 1);
      pending_text.push_back(it);
    end
  endtask

  function automatic string pick_number();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return "0";
    if (r == 1) return $sformatf("%0d", $urandom_range(60000, 999999));
    if (r < 5) return $sformatf("%0d", 1 << $urandom_range(0, 5));
    return $sformatf("%0d", $urandom_range(1, 300));
  endfunction

  function automatic string random_tune();
    string s, letters, seps;
    int unsigned nk, nn, pos;
    letters = "ABCDEFGPabcdefgp";
    seps = ", \n";
    s = "";
    repeat ($urandom_range(0, 4)) s = {s, string'(8'($urandom_range(97, 122)))};
    s = {s, ":"};
    nk = $urandom_range(0, 3);
    for (int k = 0; k < nk; k++) begin
      case ($urandom_range(0, 5))
        0: s = {s, "d="};
        1: s = {s, "D="};
        2: s = {s, "o="};
        3: s = {s, "O="};
        4: s = {s, "b="};
        default: s = {s, "B="};
      endcase
      if ($urandom_range(0, 9) != 0) s = {s, pick_number()};
      if (k < nk - 1 || $urandom_range(0, 4) == 0) s = {s, string'(seps[$urandom_range(0, 2)])};
    end
    s = {s, ":"};
    nn = $urandom_range(1, 7);
    for (int k = 0; k < nn; k++) begin
      if ($urandom_range(0, 1)) s = {s, pick_number()};
      s = {s, string'(letters[$urandom_range(0, 15)])};
      if ($urandom_range(0, 2) == 0) s = {s, "#"};
      if ($urandom_range(0, 3) == 0) s = {s, "."};
      if ($urandom_range(0, 1)) s = {s, $sformatf("%0d", $urandom_range(0, 12))};
      if (k < nn - 1 || $urandom_range(0, 1)) s = {s, ","};
    end
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, s.len() - 1);
      s[pos] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
    return s;
  endfunction

  function automatic string random_noise();
    string s;
    s = "";
    repeat ($urandom_range(1, 12)) s = {s, string'(8'($urandom_range(0, 255)))};
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_text.size() > 0 || push || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    string s;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    text_byte = 8'h00;
    end_of_text = 1'b0;
    dflt_len = 4;
    dflt_oct = 4;
    bpm = 120;
    clear_parse();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_text("x:d=8,O=12,b=63:16e6,p.,b#9,A.,c");
    add_text("q:b=:c");
    add_text("q:dx");
    add_text("q::99999c,c?c,");
    add_text("q:o=");
    add_text("nm");
    wait_drained();

    while (n_sent < ITEM_TARGET) begin
      s = ($urandom_range(0, 7) == 0) ? random_noise() : random_tune();
      add_text(s);
      while (pending_text.size() > 0) @(posedge clk);
      if (n_sent > ITEM_TARGET / 2 && n_sent < ITEM_TARGET / 2 + 40) wait_drained();
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("sent %0d text bytes; checked %0d notes, %0d rests, %0d stops",
             n_sent, n_notes, n_rests, n_stops);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** ringtone_text_note_parser: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("** ringtone_text_note_parser: FAILED **");
    end
    $finish;
  end

endmodule
